### design/gspc_pkg.sv
package gspc_pkg;

    // input operation codes
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_SAMPLE   = 2'd1;
    localparam logic [1:0] OP_STEP_END = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_COMMAND  = 2'd0;
    localparam logic [1:0] KIND_PROGRESS = 2'd1;
    localparam logic [1:0] KIND_FINAL    = 2'd2;

    // final status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_WIPER_FAIL = 2'd1;
    localparam logic [1:0] STATUS_SWEEP_FAIL = 2'd2;

    // register indexes (word address)
    localparam logic [1:0] REG_START_WIPER = 2'd0;
    localparam logic [1:0] REG_END_WIPER   = 2'd1;
    localparam logic [1:0] REG_SWEEPS      = 2'd2;
    localparam logic [1:0] REG_THRESHOLD   = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [7:0]         RST_START_WIPER = 8'd0;
    localparam logic [7:0]         RST_END_WIPER   = 8'd255;
    localparam logic [6:0]         RST_SWEEPS      = 7'd5;
    localparam logic signed [23:0] RST_THRESHOLD   = 24'sd7549746;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [23:0] blue_adc;
        logic signed [23:0] green_adc;
        logic               wiper_ok;
        logic               sweep_ok;
    } gspc_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         wiper;
        logic [7:0]         green_wiper;
        logic signed [23:0] blue_peak;
        logic signed [23:0] green_peak;
        logic               blue_sat;
        logic               green_sat;
        logic               blue_found;
        logic               green_found;
        logic [1:0]         status;
        logic [6:0]         sweeps_requested;
        logic               last;
    } gspc_out_t;

    typedef struct packed {
        logic [7:0]         first_wiper;
        logic [7:0]         last_wiper;
        logic [6:0]         sweep_num;
        logic signed [23:0] sat_level;
    } gspc_cfg_t;

    // results produced by one item: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        gspc_out_t  first;
        gspc_out_t  second;
    } gspc_res_pair_t;

endpackage

### design/gspc_apb.sv
module gspc_apb (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gspc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [gspc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gspc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output gspc_pkg::gspc_cfg_t                  cfg
);
    import gspc_pkg::*;

    gspc_cfg_t cfg_reg;
    gspc_cfg_t cfg_next;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_START_WIPER: cfg_next.first_wiper = pwdata[7:0];
                REG_END_WIPER:   cfg_next.last_wiper  = pwdata[7:0];
                REG_SWEEPS:      cfg_next.sweep_num   = pwdata[6:0];
                REG_THRESHOLD:   cfg_next.sat_level   = pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_WIPER: prdata = {24'd0, cfg_reg.first_wiper};
            REG_END_WIPER:   prdata = {24'd0, cfg_reg.last_wiper};
            REG_SWEEPS:      prdata = {25'd0, cfg_reg.sweep_num};
            REG_THRESHOLD:   prdata = {{8{cfg_reg.sat_level[23]}},
                                       cfg_reg.sat_level};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_wiper <= RST_START_WIPER;
            cfg_reg.last_wiper  <= RST_END_WIPER;
            cfg_reg.sweep_num   <= RST_SWEEPS;
            cfg_reg.sat_level   <= RST_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/gspc_core.sv
module gspc_core #(
    parameter int MAX_SWEEPS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     proc,
    input  gspc_pkg::gspc_in_t       item,
    input  gspc_pkg::gspc_cfg_t      cfg,
    output gspc_pkg::gspc_res_pair_t res
);
    import gspc_pkg::*;

    // a 7-bit field cannot exceed 127, so a larger cap never bites
    localparam logic [6:0] SWEEP_CAP = (MAX_SWEEPS > 127) ? 7'd127 : 7'(MAX_SWEEPS);

    logic [7:0]         current_wiper_reg,    current_wiper_next;
    logic signed [23:0] blue_step_max_reg,    blue_step_max_next;
    logic signed [23:0] green_step_max_reg,   green_step_max_next;
    logic               sample_seen_reg,      sample_seen_next;
    logic signed [23:0] blue_best_max_reg,    blue_best_max_next;
    logic signed [23:0] green_best_max_reg,   green_best_max_next;
    logic [7:0]         blue_best_wiper_reg,  blue_best_wiper_next;
    logic [7:0]         green_best_wiper_reg, green_best_wiper_next;
    logic               blue_valid_reg,       blue_valid_next;
    logic               green_valid_reg,      green_valid_next;
    logic               busy_reg,             busy_next;

    logic [6:0]         sweeps_n;
    logic               bsat, gsat, b_take, g_take;
    logic signed [23:0] b_best_upd, g_best_upd;
    logic [7:0]         b_wiper_upd, g_wiper_upd;
    logic               b_valid_upd, g_valid_upd;
    logic [7:0]         next_wiper;

    function automatic gspc_out_t final_res(
        input logic [1:0]         status,
        input logic [7:0]         bw,
        input logic [7:0]         gw,
        input logic signed [23:0] bm,
        input logic signed [23:0] gm,
        input logic               bv,
        input logic               gv
    );
        gspc_out_t r;
        r             = '0;
        r.kind        = KIND_FINAL;
        r.wiper       = bw;
        r.green_wiper = gw;
        r.blue_peak   = bm;
        r.green_peak  = gm;
        r.blue_found  = bv;
        r.green_found = gv;
        r.status      = status;
        return r;
    endfunction

    function automatic gspc_out_t cmd_res(input logic [7:0] code, input logic [6:0] n);
        gspc_out_t r;
        r                  = '0;
        r.kind             = KIND_COMMAND;
        r.wiper            = code;
        r.sweeps_requested = n;
        return r;
    endfunction

    assign sweeps_n   = (cfg.sweep_num > SWEEP_CAP) ? SWEEP_CAP : cfg.sweep_num;
    assign next_wiper = current_wiper_reg + 8'd1;

    // step-end judgement on the finished step maxima
    assign bsat   = blue_step_max_reg >= cfg.sat_level;
    assign gsat   = green_step_max_reg >= cfg.sat_level;
    assign b_take = !bsat && (!blue_valid_reg || blue_step_max_reg > blue_best_max_reg);
    assign g_take = !gsat && (!green_valid_reg || green_step_max_reg > green_best_max_reg);

    assign b_best_upd  = b_take ? blue_step_max_reg  : blue_best_max_reg;
    assign g_best_upd  = g_take ? green_step_max_reg : green_best_max_reg;
    assign b_wiper_upd = b_take ? current_wiper_reg  : blue_best_wiper_reg;
    assign g_wiper_upd = g_take ? current_wiper_reg  : green_best_wiper_reg;
    assign b_valid_upd = b_take | blue_valid_reg;
    assign g_valid_upd = g_take | green_valid_reg;

    always_comb begin
        current_wiper_next    = current_wiper_reg;
        blue_step_max_next    = blue_step_max_reg;
        green_step_max_next   = green_step_max_reg;
        sample_seen_next      = sample_seen_reg;
        blue_best_max_next    = blue_best_max_reg;
        green_best_max_next   = green_best_max_reg;
        blue_best_wiper_next  = blue_best_wiper_reg;
        green_best_wiper_next = green_best_wiper_reg;
        blue_valid_next       = blue_valid_reg;
        green_valid_next      = green_valid_reg;
        busy_next             = busy_reg;
        res                   = '0;

        if (proc) begin
            unique case (item.op)
                OP_START: begin
                    blue_best_max_next    = '0;
                    green_best_max_next   = '0;
                    blue_best_wiper_next  = '0;
                    green_best_wiper_next = '0;
                    blue_valid_next       = 1'b0;
                    green_valid_next      = 1'b0;
                    current_wiper_next    = cfg.first_wiper;
                    blue_step_max_next    = '0;
                    green_step_max_next   = '0;
                    sample_seen_next      = 1'b0;
                    res.count             = 2'd1;
                    if (cfg.first_wiper > cfg.last_wiper) begin
                        // empty range: done at once, nothing found
                        busy_next = 1'b0;
                        res.first = final_res(STATUS_OK, '0, '0, '0, '0, 1'b0, 1'b0);
                    end else begin
                        busy_next = 1'b1;
                        res.first = cmd_res(cfg.first_wiper, sweeps_n);
                    end
                    res.first.last = 1'b1;
                end
                OP_SAMPLE: begin
                    if (busy_reg) begin
                        if (!sample_seen_reg || item.blue_adc > blue_step_max_reg) begin
                            blue_step_max_next = item.blue_adc;
                        end
                        if (!sample_seen_reg || item.green_adc > green_step_max_reg) begin
                            green_step_max_next = item.green_adc;
                        end
                        sample_seen_next = 1'b1;
                    end
                end
                OP_STEP_END: begin
                    if (busy_reg) begin
                        priority if (!item.wiper_ok) begin
                            busy_next      = 1'b0;
                            res.count      = 2'd1;
                            res.first      = final_res(STATUS_WIPER_FAIL,
                                blue_best_wiper_reg, green_best_wiper_reg,
                                blue_best_max_reg, green_best_max_reg,
                                blue_valid_reg, green_valid_reg);
                            res.first.last = 1'b1;
                        end else if (!item.sweep_ok) begin
                            busy_next      = 1'b0;
                            res.count      = 2'd1;
                            res.first      = final_res(STATUS_SWEEP_FAIL,
                                blue_best_wiper_reg, green_best_wiper_reg,
                                blue_best_max_reg, green_best_max_reg,
                                blue_valid_reg, green_valid_reg);
                            res.first.last = 1'b1;
                        end else begin
                            blue_best_max_next    = b_best_upd;
                            green_best_max_next   = g_best_upd;
                            blue_best_wiper_next  = b_wiper_upd;
                            green_best_wiper_next = g_wiper_upd;
                            blue_valid_next       = b_valid_upd;
                            green_valid_next      = g_valid_upd;

                            res.count            = 2'd2;
                            res.first.kind       = KIND_PROGRESS;
                            res.first.wiper      = current_wiper_reg;
                            res.first.blue_peak  = blue_step_max_reg;
                            res.first.green_peak = green_step_max_reg;
                            res.first.blue_sat   = bsat;
                            res.first.green_sat  = gsat;

                            if (current_wiper_reg >= cfg.last_wiper) begin
                                busy_next  = 1'b0;
                                res.second = final_res(STATUS_OK, b_wiper_upd, g_wiper_upd,
                                    b_best_upd, g_best_upd, b_valid_upd, g_valid_upd);
                            end else begin
                                current_wiper_next  = next_wiper;
                                blue_step_max_next  = '0;
                                green_step_max_next = '0;
                                sample_seen_next    = 1'b0;
                                res.second          = cmd_res(next_wiper, sweeps_n);
                            end
                            res.second.last = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_wiper_reg    <= '0;
            blue_step_max_reg    <= '0;
            green_step_max_reg   <= '0;
            sample_seen_reg      <= 1'b0;
            blue_best_max_reg    <= '0;
            green_best_max_reg   <= '0;
            blue_best_wiper_reg  <= '0;
            green_best_wiper_reg <= '0;
            blue_valid_reg       <= 1'b0;
            green_valid_reg      <= 1'b0;
            busy_reg             <= 1'b0;
        end else begin
            current_wiper_reg    <= current_wiper_next;
            blue_step_max_reg    <= blue_step_max_next;
            green_step_max_reg   <= green_step_max_next;
            sample_seen_reg      <= sample_seen_next;
            blue_best_max_reg    <= blue_best_max_next;
            green_best_max_reg   <= green_best_max_next;
            blue_best_wiper_reg  <= blue_best_wiper_next;
            green_best_wiper_reg <= green_best_wiper_next;
            blue_valid_reg       <= blue_valid_next;
            green_valid_reg      <= green_valid_next;
            busy_reg             <= busy_next;
        end
    end

`ifndef SYNTH
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && item.op == OP_START && cfg.first_wiper <= cfg.last_wiper |=> busy_reg)
        else $error("start with a valid range did not begin a run");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !busy_reg && (item.op == OP_SAMPLE || item.op == OP_STEP_END)
        |-> res.count == 2'd0)
        else $error("idle block produced a result");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        res.count == 2'd2 |-> res.first.kind == KIND_PROGRESS && !res.first.last
        && res.second.last)
        else $error("result pair out of order");

    a_best_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && item.op == OP_STEP_END && busy_reg && item.wiper_ok && item.sweep_ok
        && bsat |=> blue_best_wiper_reg == $past(blue_best_wiper_reg))
        else $error("saturated step replaced the blue best code");
`endif

endmodule

### design/gspc_out_fifo.sv
module gspc_out_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gspc_pkg::gspc_res_pair_t wr,
    output logic                     room,
    output logic                     m_valid,
    input  logic                     m_ready,
    output gspc_pkg::gspc_out_t      m_data
);
    import gspc_pkg::*;

    gspc_out_t           entry_reg [QDEPTH];
    gspc_out_t           entry_next [QDEPTH];
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   tail_plus1;
    logic                pop;

    assign m_valid    = count_reg != '0;
    assign m_data     = entry_reg[head_reg];
    assign pop        = m_valid && m_ready;
    // two free slots: enough for the largest burst of one transaction
    assign room       = count_reg <= QCNT_W'(QDEPTH - 2);
    assign tail_plus1 = tail_reg + QPTR_W'(1);

    always_comb begin
        entry_next = entry_reg;
        if (wr.count != 2'd0) begin
            entry_next[tail_reg] = wr.first;
        end
        if (wr.count == 2'd2) begin
            entry_next[tail_plus1] = wr.second;
        end
        tail_next  = tail_reg + QPTR_W'(wr.count);
        head_next  = pop ? head_reg + QPTR_W'(1) : head_reg;
        count_next = count_reg + QCNT_W'(wr.count) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.count != 2'd0 |-> 32'(count_reg) + 32'(wr.count) <= QDEPTH)
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && wr.count == 2'd0 |=> count_reg == $past(count_reg) - QCNT_W'(1))
        else $error("queue count did not follow a pop");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != QCNT_W'(QDEPTH) |-> (tail_reg - head_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

### design/gain_sweep_peak_calibrator.sv
// path: a taken input transaction is registered, then worked on once the queue has room;
//   its results go into the result queue, two at once for a step end that closes a step
// throughput: one input transaction per cycle while the four-entry result queue has two
//   free slots; results leave one per cycle while m_ready is high, setting the long-run rate
// reset: aresetn is synchronous and active low; it restores the register defaults,
//   idles the sweep, clears the best-code tracking and empties the result queue
module gain_sweep_peak_calibrator #(
    parameter int MAX_SWEEPS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gspc_pkg::gspc_in_t              s_data,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output gspc_pkg::gspc_out_t             m_data,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gspc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gspc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gspc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import gspc_pkg::*;

    gspc_in_t       in_item_reg, in_item_next;
    logic           in_vld_reg,  in_vld_next;
    logic           room;
    logic           proc;
    logic           s_take;
    gspc_cfg_t      cfg;
    gspc_res_pair_t res;

    // the held transaction is worked on once the queue can absorb its results
    assign proc   = in_vld_reg && room;
    // input register frees up in the same cycle it is worked on
    assign s_ready = !in_vld_reg || room;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_item_next = s_take ? s_data : in_item_reg;
        if (s_take) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    // configuration registers behind the bus port
    gspc_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sweep state, running maxima and best-code tracking; builds up to two results
    gspc_core #(
        .MAX_SWEEPS (MAX_SWEEPS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (proc),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // result queue decouples the two sides and serializes result pairs
    gspc_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
